// File: src/kta_pkg.sv
// Package with the shared widths, command and status codes and transaction types of the table.
package kta_pkg;

    localparam int CMD_W       = 2;
    localparam int KEY_W       = 16;
    localparam int TAG_W       = 16;
    localparam int STATUS_W    = 3;
    localparam int SLOT_W      = 7;
    localparam int ENTRIES_DEF = 64;

    localparam logic [CMD_W-1:0] CMD_REG  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd4;

    // A command as it travels down the row of cells, with the search flags gathered so far.
    typedef struct packed {
        logic             vld;
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             zero;
        logic             dup;
        logic             free_vld;
        logic             hit_vld;
        logic [KEY_W-1:0] hit_key;
    } pkt_t;

    // Deferred write of a new entry, issued when a register command leaves the row.
    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } wr_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [KEY_W-1:0]    found_key;
    } res_t;

endpackage

// File: src/kta_req_if.sv
// Interface for the command channel of the table.
interface kta_req_if;
    import kta_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;

    modport source (output valid, output cmd, output key, output tag, input ready);
    modport sink (input valid, input cmd, input key, input tag, output ready);
endinterface

// File: src/kta_rsp_if.sv
// Interface for the result channel of the table.
interface kta_rsp_if;
    import kta_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    found_key;

    modport source (output valid, output status, output slot, output found_key, input ready);
    modport sink (input valid, input status, input slot, input found_key, output ready);
endinterface

// File: src/key_tag_associative_table.sv
// Top level of the key and tag table: a row of slot cells that each transaction walks through.
// A transaction enters the first cell when accepted and moves one cell per cycle.
// Its result leaves the last cell into a pending register, then moves to the output register.
// One transaction is in the row at a time; the next waits for an empty row and pending register.
// A result may wait at the output while the next transaction walks the row.
// Reset is asynchronous and active low; it frees every slot at once.
module key_tag_associative_table #(
    parameter int ENTRIES = kta_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    kta_req_if.sink     req,
    kta_rsp_if.source   rsp
);
    import kta_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    pkt_t             chain_pkt  [ENTRIES+1];
    logic [IDX_W-1:0] chain_free [ENTRIES+1];
    logic [IDX_W-1:0] chain_hit  [ENTRIES+1];

    wr_t              wr;
    logic [IDX_W-1:0] wr_pos;
    pkt_t             end_pkt;
    logic             accept;
    logic             zero_op;
    res_t             res;
    logic [IDX_W:0]   free_slot;
    logic [IDX_W:0]   hit_slot;

    logic busy_reg, busy_next;
    logic pend_vld_reg, pend_vld_next;
    logic out_vld_reg, out_vld_next;
    res_t pend_reg, pend_next;
    res_t out_reg, out_next;

    assign req.ready = !busy_reg && !pend_vld_reg;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        unique case (req.cmd)
            CMD_REG, CMD_DEL: zero_op = (req.key == '0);
            CMD_FIND:         zero_op = (req.tag == '0);
            CMD_CLR:          zero_op = 1'b0;
        endcase
    end

    always_comb
    begin
        chain_pkt[0]          = '0;
        chain_pkt[0].vld      = accept;
        chain_pkt[0].cmd      = req.cmd;
        chain_pkt[0].key      = req.key;
        chain_pkt[0].tag      = req.tag;
        chain_pkt[0].zero     = zero_op;
    end

    assign chain_free[0] = '0;
    assign chain_hit[0]  = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        kta_cell #(
            .ENTRIES  (ENTRIES),
            .CELL_IDX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .pkt_in       (chain_pkt[i]),
            .free_pos_in  (chain_free[i]),
            .hit_pos_in   (chain_hit[i]),
            .wr           (wr),
            .wr_pos       (wr_pos),
            .pkt_out      (chain_pkt[i+1]),
            .free_pos_out (chain_free[i+1]),
            .hit_pos_out  (chain_hit[i+1])
        );
    end

    assign end_pkt   = chain_pkt[ENTRIES];
    assign free_slot = {1'b0, chain_free[ENTRIES]} + (IDX_W+1)'(1);
    assign hit_slot  = {1'b0, chain_hit[ENTRIES]} + (IDX_W+1)'(1);

    always_comb
    begin
        res    = '0;
        wr     = '0;
        wr.key = end_pkt.key;
        wr.tag = end_pkt.tag;
        wr_pos = chain_free[ENTRIES];
        if (end_pkt.zero)
        begin
            res.status = ST_ZERO;
        end
        else
        begin
            unique case (end_pkt.cmd)
                CMD_REG:
                begin
                    if (end_pkt.dup)
                    begin
                        res.status = ST_DUP;
                    end
                    else if (end_pkt.free_vld)
                    begin
                        res.status = ST_OK;
                        res.slot   = SLOT_W'(free_slot);
                        wr.en      = end_pkt.vld;
                    end
                    else
                    begin
                        res.status = ST_FULL;
                    end
                end
                CMD_FIND:
                begin
                    if (end_pkt.hit_vld)
                    begin
                        res.status    = ST_OK;
                        res.slot      = SLOT_W'(hit_slot);
                        res.found_key = end_pkt.hit_key;
                    end
                    else
                    begin
                        res.status = ST_NOTFOUND;
                    end
                end
                CMD_DEL:
                begin
                    if (end_pkt.hit_vld)
                    begin
                        res.status = ST_OK;
                        res.slot   = SLOT_W'(hit_slot);
                    end
                    else
                    begin
                        res.status = ST_NOTFOUND;
                    end
                end
                CMD_CLR:
                begin
                    res.status = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        busy_next     = busy_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (!out_vld_reg || rsp.ready)
        begin
            out_vld_next = pend_vld_reg;
            out_next     = pend_reg;
            pend_vld_next = 1'b0;
        end
        if (end_pkt.vld)
        begin
            busy_next     = 1'b0;
            pend_vld_next = 1'b1;
            pend_next     = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign rsp.valid     = out_vld_reg;
    assign rsp.status    = out_reg.status;
    assign rsp.slot      = out_reg.slot;
    assign rsp.found_key = out_reg.found_key;

endmodule

// File: src/kta_cell.sv
// One slot of the table: holds a key and tag pair and processes a passing transaction.
module kta_cell #(
    parameter int ENTRIES  = kta_pkg::ENTRIES_DEF,
    parameter int CELL_IDX = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kta_pkg::pkt_t                pkt_in,
    input  logic [$clog2(ENTRIES)-1:0]   free_pos_in,
    input  logic [$clog2(ENTRIES)-1:0]   hit_pos_in,
    input  kta_pkg::wr_t                 wr,
    input  logic [$clog2(ENTRIES)-1:0]   wr_pos,
    output kta_pkg::pkt_t                pkt_out,
    output logic [$clog2(ENTRIES)-1:0]   free_pos_out,
    output logic [$clog2(ENTRIES)-1:0]   hit_pos_out
);
    import kta_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] OWN = IDX_W'(CELL_IDX);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    pkt_t             pkt_reg, pkt_next;
    logic [IDX_W-1:0] free_pos_reg, free_pos_next;
    logic [IDX_W-1:0] hit_pos_reg, hit_pos_next;

    always_comb
    begin
        pkt_next      = pkt_in;
        free_pos_next = free_pos_in;
        hit_pos_next  = hit_pos_in;
        key_next      = key_reg;
        tag_next      = tag_reg;
        if (pkt_in.vld && !pkt_in.zero)
        begin
            unique case (pkt_in.cmd)
                CMD_REG:
                begin
                    if (key_reg == pkt_in.key)
                    begin
                        pkt_next.dup = 1'b1;
                    end
                    if (!pkt_in.free_vld && key_reg == '0)
                    begin
                        pkt_next.free_vld = 1'b1;
                        free_pos_next     = OWN;
                    end
                end
                CMD_FIND:
                begin
                    if (!pkt_in.hit_vld && tag_reg == pkt_in.tag)
                    begin
                        pkt_next.hit_vld = 1'b1;
                        pkt_next.hit_key = key_reg;
                        hit_pos_next     = OWN;
                    end
                end
                CMD_DEL:
                begin
                    if (!pkt_in.hit_vld && key_reg == pkt_in.key)
                    begin
                        pkt_next.hit_vld = 1'b1;
                        hit_pos_next     = OWN;
                        key_next         = '0;
                        tag_next         = '0;
                    end
                end
                CMD_CLR:
                begin
                    key_next = '0;
                    tag_next = '0;
                end
            endcase
        end
        if (wr.en && wr_pos == OWN)
        begin
            key_next = wr.key;
            tag_next = wr.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
            tag_reg <= '0;
            pkt_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
            tag_reg <= tag_next;
            pkt_reg <= pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_pos_reg <= free_pos_next;
        hit_pos_reg  <= hit_pos_next;
    end

    assign pkt_out      = pkt_reg;
    assign free_pos_out = free_pos_reg;
    assign hit_pos_out  = hit_pos_reg;

endmodule
